// File: sv/timed_blind_position_controller_core_macros.svh
// Assertion macros for the timed blind position controller core.
`ifndef TIMED_BLIND_POSITION_CONTROLLER_CORE_MACROS_SVH
`define TIMED_BLIND_POSITION_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TBPC_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("tbpc check failed");

// Next-cycle implication, checked outside reset.
`define TBPC_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("tbpc check failed");

`endif

// File: sv/tbpc_pkg.sv
// Package: constants and codes of the timed blind position controller.
`default_nettype none
package tbpc_pkg;
    localparam int TICK_W = 13;
    localparam int PCT_W  = 8;
    localparam int COV_W  = 7;
    localparam int MODE_W = 8;
    localparam int MAG_W  = 20;
    localparam int IDX_W  = 2;

    localparam logic [TICK_W-1:0] TOP_POS_RST  = 13'd500;
    localparam logic [TICK_W-1:0] BOT_POS_RST  = 13'd4650;
    localparam logic [TICK_W-1:0] TOP_LIM_RST  = 13'd200;
    localparam logic [TICK_W-1:0] BOT_LIM_RST  = 13'd4950;

    localparam logic [PCT_W-1:0] PCT_FULL_OPEN  = 8'd0;
    localparam logic [PCT_W-1:0] PCT_FULL_CLOSE = 8'd100;
    localparam logic [MAG_W-1:0] DIV_ROUND_UP   = 20'd99;

    // floor(m / 100) = (m * RECIP_100) >> RECIP_SHIFT for m < 2^20
    localparam int RECIP_SHIFT = 27;
    localparam logic [20:0] RECIP_100 = 21'd1342178;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_COVER = 1'b1;

    localparam logic [IDX_W-1:0] REG_TOP_POS = 2'd0;
    localparam logic [IDX_W-1:0] REG_BOT_POS = 2'd1;
    localparam logic [IDX_W-1:0] REG_TOP_LIM = 2'd2;
    localparam logic [IDX_W-1:0] REG_BOT_LIM = 2'd3;
endpackage
`default_nettype wire

// File: sv/timed_blind_position_controller_core.sv
// Top level: roller blind position estimator driven by ticks and cover commands.
// One item in, one result out, one item per cycle sustained while m_tready holds high.
// From acceptance to result: after the input register come the |bottom-top| * percent
// product, the reciprocal division by 100, then the state update whose new state is the
// result register. Only the last stage reads the position state, so items follow each
// other without gaps. Configuration writes are always taken (cfg_ready high) and must
// happen with the block idle.
`default_nettype none
`include "timed_blind_position_controller_core_macros.svh"
module timed_blind_position_controller_core
    import tbpc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output      logic              s_tready,
    input  wire logic [15:0]       s_tdata,   // cover_percent[7:0], blind_mode[15:8]
    input  wire logic              s_tuser,   // operation
    output      logic              m_tvalid,
    input  wire logic              m_tready,
    output      logic [47:0]       m_tdata,   // motor_running, moving_up, position_ticks,
                                              // target_ticks, current_cover, current_mode
    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [TICK_W-1:0] cfg_data
);
    logic [TICK_W-1:0] top_pos_reg, bot_pos_reg, top_lim_reg, bot_lim_reg;

    logic              v0_reg, v1_reg, v2_reg, m_tvalid_reg;
    logic              op0_reg, op1_reg, op2_reg;
    logic [PCT_W-1:0]  pct0_reg, pct1_reg, pct2_reg;
    logic [MODE_W-1:0] mb0_reg, mb1_reg, mb2_reg;
    logic [MAG_W-1:0]  mag1_reg;
    logic              neg1_reg, neg2_reg;
    logic [TICK_W-1:0] q2_reg;

    logic [TICK_W-1:0] pos_reg, pos_next, tgt_reg, tgt_next;
    logic              up_reg, up_next, run_reg, run_next;
    logic [COV_W-1:0]  cov_reg, cov_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    logic adv0, adv1, adv2;
    logic signed [TICK_W:0] diff;
    logic [TICK_W:0]        abs_diff;
    logic [MAG_W-1:0]       mag_next, m_adj;
    logic [40:0]            prod;
    logic [TICK_W-1:0]      interp, cmd_tgt, pos_dec, pos_inc;

    assign adv2     = !m_tvalid_reg || m_tready;
    assign adv1     = !v2_reg || adv2;
    assign adv0     = !v1_reg || adv1;
    assign s_tready = !v0_reg || adv0;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_pos_reg <= TOP_POS_RST;
            bot_pos_reg <= BOT_POS_RST;
            top_lim_reg <= TOP_LIM_RST;
            bot_lim_reg <= BOT_LIM_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TOP_POS: top_pos_reg <= cfg_data;
                REG_BOT_POS: bot_pos_reg <= cfg_data;
                REG_TOP_LIM: top_lim_reg <= cfg_data;
                REG_BOT_LIM: bot_lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: |bottom - top| * percent
    always_comb begin
        diff     = $signed({1'b0, bot_pos_reg}) - $signed({1'b0, top_pos_reg});
        abs_diff = diff[TICK_W] ? 14'(-diff) : 14'(diff);
        mag_next = MAG_W'(pct0_reg[COV_W-1:0] * abs_diff[TICK_W-1:0]);
    end

    // stage 2: floor division by 100, rounding toward minus infinity when negative
    always_comb begin
        m_adj = neg1_reg ? mag1_reg + DIV_ROUND_UP : mag1_reg;
        prod  = m_adj * RECIP_100;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (s_tready) v0_reg <= s_tvalid;
            if (adv0)     v1_reg <= v0_reg;
            if (adv1)     v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            op0_reg  <= s_tuser;
            pct0_reg <= s_tdata[7:0];
            mb0_reg  <= s_tdata[15:8];
        end
        if (adv0) begin
            op1_reg  <= op0_reg;
            pct1_reg <= pct0_reg;
            mb1_reg  <= mb0_reg;
            mag1_reg <= mag_next;
            neg1_reg <= diff[TICK_W];
        end
        if (adv1) begin
            op2_reg  <= op1_reg;
            pct2_reg <= pct1_reg;
            mb2_reg  <= mb1_reg;
            q2_reg   <= prod[RECIP_SHIFT+TICK_W-1:RECIP_SHIFT];
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: state update
    always_comb begin
        interp = neg2_reg ? top_pos_reg - q2_reg : top_pos_reg + q2_reg;
        if (pct2_reg == PCT_FULL_OPEN) begin
            cmd_tgt = top_lim_reg;
        end else if (pct2_reg == PCT_FULL_CLOSE) begin
            cmd_tgt = bot_lim_reg;
        end else begin
            cmd_tgt = interp;
        end
        pos_dec   = pos_reg - 13'd1;
        pos_inc   = pos_reg + 13'd1;
        pos_next  = pos_reg;
        tgt_next  = tgt_reg;
        up_next   = up_reg;
        run_next  = run_reg;
        cov_next  = cov_reg;
        mode_next = mode_reg;
        if (op2_reg == OP_COVER) begin
            mode_next = mb2_reg;
            if (pct2_reg <= PCT_FULL_CLOSE && pct2_reg != {1'b0, cov_reg}) begin
                cov_next = pct2_reg[COV_W-1:0];
                tgt_next = cmd_tgt;
                if (cmd_tgt != pos_reg) begin
                    up_next  = cmd_tgt < pos_reg;
                    run_next = 1'b1;
                end
            end
        end else if (run_reg) begin
            if (up_reg) begin
                pos_next = pos_dec;
                if (pos_dec <= tgt_reg || pos_dec < top_lim_reg) begin
                    run_next = 1'b0;
                    if (pos_dec <= top_lim_reg) pos_next = top_pos_reg;
                end
            end else begin
                pos_next = pos_inc;
                if (pos_inc >= tgt_reg || pos_inc > bot_lim_reg) begin
                    run_next = 1'b0;
                    if (pos_inc >= bot_lim_reg) pos_next = bot_pos_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= BOT_POS_RST;
            tgt_reg      <= TOP_LIM_RST;
            up_reg       <= 1'b1;
            run_reg      <= 1'b1;
            cov_reg      <= '0;
            mode_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv2) begin
            m_tvalid_reg <= v2_reg;
            if (v2_reg) begin
                pos_reg  <= pos_next;
                tgt_reg  <= tgt_next;
                up_reg   <= up_next;
                run_reg  <= run_next;
                cov_reg  <= cov_next;
                mode_reg <= mode_next;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, mode_reg, cov_reg, tgt_reg, pos_reg, up_reg, run_reg};

    `TBPC_ASSERT_NEXT(a_pos_hold, !(v2_reg && adv2), $stable(pos_reg) && $stable(tgt_reg))
    `TBPC_ASSERT_NEXT(a_result_out, v2_reg && adv2, m_tvalid)
    `TBPC_ASSERT_NEXT(a_bad_pct, v2_reg && adv2 && op2_reg == OP_COVER && pct2_reg > PCT_FULL_CLOSE,
        $stable(tgt_reg) && $stable(cov_reg))
    `TBPC_ASSERT_NOW(a_ready_empty, !v0_reg, s_tready)
endmodule
`default_nettype wire

// File: bench/tb_timed_blind_position_controller_core.sv
// Testbench for the timed blind position controller core: random item streams checked by a predictor.
module tb_timed_blind_position_controller_core;
    import tbpc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int REG_MAX     = 8190;

    typedef struct {
        logic             op;
        logic [PCT_W-1:0] pct;
        logic [MODE_W-1:0] mode;
    } blind_item_t;

    typedef struct {
        logic              running;
        logic              up;
        logic [TICK_W-1:0] pos;
        logic [TICK_W-1:0] tgt;
        logic [COV_W-1:0]  cover_pct;
        logic [MODE_W-1:0] mode;
    } blind_status_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;    // cover_percent[7:0], blind_mode[15:8]
    logic              s_tuser   = 1'b0;  // operation
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [47:0]       m_tdata;           // motor_running, moving_up, position_ticks,
                                          // target_ticks, current_cover, current_mode
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [TICK_W-1:0] cfg_data  = '0;

    // predicted block state and registers
    logic [TICK_W-1:0] cfg_top     = TOP_POS_RST;
    logic [TICK_W-1:0] cfg_bot     = BOT_POS_RST;
    logic [TICK_W-1:0] cfg_top_lim = TOP_LIM_RST;
    logic [TICK_W-1:0] cfg_bot_lim = BOT_LIM_RST;
    logic [TICK_W-1:0] blind_pos   = BOT_POS_RST;
    logic [TICK_W-1:0] blind_tgt   = TOP_LIM_RST;
    logic              blind_up    = 1'b1;
    logic              blind_run   = 1'b1;
    logic [COV_W-1:0]  blind_cover = '0;
    logic [MODE_W-1:0] blind_mode  = '0;

    blind_item_t   blind_items[$];
    blind_status_t expected_status[$];
    blind_item_t   next_item;
    int            mismatches  = 0;
    int            cycle_count = 0;
    logic          quiet_run   = 1'b0;

    timed_blind_position_controller_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic take_break();
        return !quiet_run && ($urandom_range(99) < 24);
    endfunction

    function automatic int clip(input int v);
        if (v < 1) return 1;
        if (v > REG_MAX) return REG_MAX;
        return v;
    endfunction

    task automatic advance_blind(input blind_item_t it);
        blind_status_t st;
        int            diff;
        int            prod;
        int            quot;
        if (it.op == OP_COVER) begin
            blind_mode = it.mode;
            if (it.pct <= PCT_FULL_CLOSE && it.pct != blind_cover) begin
                blind_cover = it.pct[COV_W-1:0];
                if (it.pct == PCT_FULL_OPEN) begin
                    blind_tgt = cfg_top_lim;
                end else if (it.pct == PCT_FULL_CLOSE) begin
                    blind_tgt = cfg_bot_lim;
                end else begin
                    diff = int'(cfg_bot) - int'(cfg_top);
                    prod = int'(it.pct) * diff;
                    quot = prod / 100;
                    if (prod % 100 != 0 && prod < 0) quot -= 1;
                    blind_tgt = TICK_W'(int'(cfg_top) + quot);
                end
                if (blind_tgt != blind_pos) begin
                    blind_up  = blind_tgt < blind_pos;
                    blind_run = 1'b1;
                end
            end
        end else if (blind_run) begin
            if (blind_up) begin
                blind_pos = blind_pos - 1'b1;
                if (blind_pos <= blind_tgt || blind_pos < cfg_top_lim) begin
                    blind_run = 1'b0;
                    if (blind_pos <= cfg_top_lim) blind_pos = cfg_top;
                end
            end else begin
                blind_pos = blind_pos + 1'b1;
                if (blind_pos >= blind_tgt || blind_pos > cfg_bot_lim) begin
                    blind_run = 1'b0;
                    if (blind_pos >= cfg_bot_lim) blind_pos = cfg_bot;
                end
            end
        end
        st.running   = blind_run;
        st.up        = blind_up;
        st.pos       = blind_pos;
        st.tgt       = blind_tgt;
        st.cover_pct = blind_cover;
        st.mode      = blind_mode;
        expected_status.push_back(st);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_status();
        blind_status_t want;
        if (expected_status.size() == 0) begin
            $error("result item with no expectation pending");
            mismatches++;
        end else begin
            want = expected_status.pop_front();
            compare_field("motor_running", want.running, m_tdata[0]);
            compare_field("moving_up", want.up, m_tdata[1]);
            compare_field("position_ticks", want.pos, m_tdata[14:2]);
            compare_field("target_ticks", want.tgt, m_tdata[27:15]);
            compare_field("current_cover", want.cover_pct, m_tdata[34:28]);
            compare_field("current_mode", want.mode, m_tdata[42:35]);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                next_item.op   = s_tuser;
                next_item.pct  = s_tdata[7:0];
                next_item.mode = s_tdata[15:8];
                advance_blind(next_item);
            end
            if (!s_tvalid || s_tready) begin
                if (blind_items.size() != 0 && !take_break()) begin
                    next_item = blind_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.op;
                    s_tdata  <= {next_item.mode, next_item.pct};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_status();
            m_tready <= !take_break();
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_tick();
        blind_item_t it;
        it.op   = OP_TICK;
        it.pct  = PCT_W'($urandom);
        it.mode = MODE_W'($urandom);
        blind_items.push_back(it);
    endtask

    task automatic push_cover(input logic [PCT_W-1:0] pct, input logic [MODE_W-1:0] mode);
        blind_item_t it;
        it.op   = OP_COVER;
        it.pct  = pct;
        it.mode = mode;
        blind_items.push_back(it);
    endtask

    task automatic tick_burst(input int n);
        repeat (n) push_tick();
    endtask

    task automatic drain();
        do @(posedge aclk);
        while (blind_items.size() != 0 || s_tvalid || expected_status.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TOP_POS: cfg_top     = value;
            REG_BOT_POS: cfg_bot     = value;
            REG_TOP_LIM: cfg_top_lim = value;
            REG_BOT_LIM: cfg_bot_lim = value;
            default:     ;
        endcase
    endtask

    task automatic retune(input int top_lim, input int top, input int bot, input int bot_lim);
        drain();
        write_reg(REG_TOP_LIM, TICK_W'(top_lim));
        write_reg(REG_TOP_POS, TICK_W'(top));
        write_reg(REG_BOT_POS, TICK_W'(bot));
        write_reg(REG_BOT_LIM, TICK_W'(bot_lim));
    endtask

    // window of random size around wherever the blind sits now
    task automatic random_window();
        int p;
        int tl;
        int bt;
        drain();
        p  = blind_pos;
        tl = clip(p - $urandom_range(0, 100));
        bt = clip(p + $urandom_range(0, 100));
        retune(tl, clip(tl + $urandom_range(0, 30)), bt, clip(bt + $urandom_range(0, 30)));
    endtask

    // commands with random percent, each followed by a run of zero to burst_max ticks, among lone ticks
    task automatic random_traffic(input int count, input int burst_max);
        int               left;
        int               n;
        int               sel;
        logic [PCT_W-1:0] pct;
        logic [PCT_W-1:0] last_pct;
        left     = count;
        last_pct = PCT_FULL_OPEN;
        while (left > 0) begin
            if ($urandom_range(99) < 65) begin
                sel = $urandom_range(99);
                if (sel < 8)       pct = PCT_FULL_OPEN;
                else if (sel < 16) pct = PCT_FULL_CLOSE;
                else if (sel < 24) pct = last_pct;
                else if (sel < 32) pct = PCT_W'($urandom_range(101, 255));
                else               pct = PCT_W'($urandom_range(1, 99));
                push_cover(pct, MODE_W'($urandom));
                if (pct <= PCT_FULL_CLOSE) last_pct = pct;
                left--;
                n = $urandom_range(0, burst_max);
                if (n > left) n = left;
                tick_burst(n);
                left -= n;
            end else begin
                push_tick();
                left--;
            end
        end
    endtask

    initial begin
        int p;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // out of reset: running up, unchanged / out of range percents, both full travels
        push_tick();
        push_cover(PCT_FULL_OPEN, 8'hA5);
        push_cover(8'd255, 8'h5A);
        push_cover(8'd101, 8'hFF);
        push_cover(PCT_FULL_CLOSE, 8'h00);
        push_tick();
        push_cover(8'd50, 8'h80);
        push_tick();
        drain();

        // tight window: overrun snaps, target equal to position stopped and running
        p = blind_pos;
        retune(clip(p - 3), clip(p - 1), clip(p + 4), clip(p + 2));
        push_cover(PCT_FULL_CLOSE, 8'h33);
        tick_burst(2);
        push_cover(PCT_FULL_OPEN, 8'hCC);
        tick_burst(8);
        push_cover(8'd1, 8'h0F);
        push_cover(PCT_FULL_CLOSE, 8'hF0);
        push_tick();
        push_cover(8'd20, 8'h96);
        push_tick();

        random_window();
        random_traffic(160, 120);

        random_window();
        quiet_run = 1'b1;
        random_traffic(160, 120);
        drain();
        quiet_run = 1'b0;

        retune(1, 1, REG_MAX, REG_MAX);
        random_traffic(150, 150);

        drain();
        p = blind_pos;
        retune(clip(p - 40), clip(p + 30), clip(p - 30), clip(p + 40));
        random_traffic(160, 100);

        random_window();
        random_traffic(160, 120);

        random_window();
        random_traffic(160, 60);

        random_window();
        random_traffic(160, 120);

        drain();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
